[rtl/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and codes for the cooperative task scheduler: opcodes, result
// status codes, walk kinds and the packed task table entry.
// ----------------------------------------------------------------------------
package cts_pkg;

  // Default table depth and the cap on results per dispatch
  localparam int MAX_TASKS_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int RES_W         = $clog2(MAX_RESULTS + 1);

  // Operation codes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_ADD      = 3'd1;
  localparam logic [2:0] OP_DELETE   = 3'd2;
  localparam logic [2:0] OP_REPLACE  = 3'd3;
  localparam logic [2:0] OP_DISPATCH = 3'd4;
  localparam logic [2:0] OP_CLEAR    = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  // Kind of table walk handed to the entry unit
  typedef logic [1:0] walk_t;
  localparam walk_t WALK_MOVE = 2'd0;
  localparam walk_t WALK_TICK = 2'd1;
  localparam walk_t WALK_DISP = 2'd2;

  // One task table entry
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] arg;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
  } entry_t;

  // Outcome of one entry visit
  typedef struct packed {
    entry_t upd;
    logic   emit;
    logic   keep;
  } step_t;

endpackage

[rtl/cts_table_mem.sv]
// ----------------------------------------------------------------------------
// cts_table_mem
// Task table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cts_table_mem
  import cts_pkg::*;
#(
  parameter int DEPTH = MAX_TASKS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/cts_entry_unit.sv]
// ----------------------------------------------------------------------------
// cts_entry_unit
// Shared entry update unit: ages an entry on tick, takes one run off it on
// dispatch and decides whether it stays in the table.
// ----------------------------------------------------------------------------
module cts_entry_unit
  import cts_pkg::*;
(
  input  walk_t  kind,
  input  entry_t cur,
  input  logic   may_emit,
  output step_t  res
);

  always_comb begin
    res.upd  = cur;
    res.emit = 1'b0;
    res.keep = 1'b1;
    unique case (kind)
      WALK_TICK: begin
        // Age only entries that carry code
        if (cur.id != 8'd0) begin
          if (cur.delay == 16'd0) begin
            if (cur.pending != 8'hFF) begin
              res.upd.pending = cur.pending + 8'd1;
            end
            if (cur.period != 16'd0) begin
              res.upd.delay = cur.period;
            end
          end else begin
            res.upd.delay = cur.delay - 16'd1;
          end
        end
      end
      WALK_DISP: begin
        // Emit a pending run; drop one-shot entries once run
        if (cur.pending != 8'd0 && may_emit) begin
          res.emit        = 1'b1;
          res.upd.pending = cur.pending - 8'd1;
          res.keep        = (cur.period != 16'd0);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/cooperative_task_scheduler.sv]
// ----------------------------------------------------------------------------
// cooperative_task_scheduler
// Time-triggered cooperative scheduler over an ordered task table.
// ----------------------------------------------------------------------------
// Add, replace, clear and unused opcodes go from acceptance straight to the
// result state. Tick and delete walk the table entry by entry: every visited
// entry passes through a read state and an update state on the single read
// port of the table memory and the one shared entry unit. Dispatch walks the
// table twice, once to count the runs and removals so that every result
// carries the final count and the last flag, and once to emit and compact;
// it ends after the counting walk when no run is pending, and the emitting
// walk stalls while the output side holds a result. The block takes no new
// item while a walk is in progress. The table needs no clearing after reset;
// only the count is cleared.
// ----------------------------------------------------------------------------
module cooperative_task_scheduler
  import cts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [3:0]  position,
  input  logic [7:0]  task_id,
  input  logic [15:0] release_time,
  input  logic [15:0] period,
  input  logic [7:0]  run_count,
  input  logic [31:0] task_arg,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  run_task_id,
  output logic [31:0] run_task_arg,
  output logic        last,
  output logic [4:0]  task_count
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int PW = (CW > 4) ? CW : 4;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_PROC = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]       state;
  logic [CW-1:0]    total;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    wptr;
  logic [CW-1:0]    removed;
  walk_t            kind;
  logic             pass2;
  logic [RES_W-1:0] n_total;
  logic [RES_W-1:0] emitted;
  logic [1:0]       rsp_status;

  entry_t           in_entry;
  entry_t           rd_data;
  entry_t           wr_data;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  step_t            step;
  logic             may_emit;
  logic             count_only;
  logic             out_free;
  logic             out_load;
  logic             proc_go;
  logic             accept;
  logic             in_range;
  logic [CW-1:0]    idx_inc;
  logic [CW-1:0]    final_cnt;
  logic [CW-1:0]    pos_inc;

  // Table storage and the shared entry unit
  cts_table_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx[IW-1:0]),
    .rdata (rd_data)
  );

  cts_entry_unit u_unit (
    .kind     (kind),
    .cur      (rd_data),
    .may_emit (may_emit),
    .res      (step)
  );

  // Decode the handshake and walk conditions
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign count_only = (kind == WALK_DISP) && !pass2;
  assign may_emit   = (pass2 ? emitted : n_total) < RES_W'(MAX_RESULTS);
  assign proc_go    = (state == S_PROC) && (!(pass2 && step.emit) || out_free);
  assign out_load   = (proc_go && pass2 && step.emit) || (state == S_RESP && out_free);
  assign in_range   = PW'(position) < PW'(total);
  assign idx_inc    = idx + CW'(1);
  assign pos_inc    = CW'(position) + CW'(1);
  assign final_cnt  = total - removed;

  assign in_entry.id      = task_id;
  assign in_entry.arg     = task_arg;
  assign in_entry.delay   = release_time;
  assign in_entry.period  = period;
  assign in_entry.pending = run_count;

  // Select the table write: an item's entry, or a walk's updated entry
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wptr[IW-1:0];
    wr_data = step.upd;
    if (accept && opcode == OP_ADD && total < CW'(MAX_TASKS)) begin
      wr_en   = 1'b1;
      wr_addr = total[IW-1:0];
      wr_data = in_entry;
    end else if (accept && opcode == OP_REPLACE && in_range) begin
      wr_en   = 1'b1;
      wr_addr = IW'(position);
      wr_data = in_entry;
    end else if (proc_go && !count_only && step.keep) begin
      wr_en = 1'b1;
    end
  end

  // Sequence operations and table walks
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop a taken result unless a new one loads this cycle
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pass2   <= 1'b0;
            n_total <= '0;
            emitted <= '0;
            removed <= '0;
            unique case (opcode)
              OP_TICK: begin
                kind       <= WALK_TICK;
                rsp_status <= ST_OK;
                idx        <= '0;
                wptr       <= '0;
                state      <= (total != '0) ? S_READ : S_RESP;
              end
              OP_ADD: begin
                state <= S_RESP;
                if (total < CW'(MAX_TASKS)) begin
                  rsp_status <= ST_OK;
                  total      <= total + CW'(1);
                end else begin
                  rsp_status <= ST_FULL;
                end
              end
              OP_DELETE: begin
                kind <= WALK_MOVE;
                idx  <= pos_inc;
                wptr <= CW'(position);
                if (!in_range) begin
                  rsp_status <= ST_RANGE;
                  state      <= S_RESP;
                end else if (pos_inc == total) begin
                  rsp_status <= ST_OK;
                  total      <= total - CW'(1);
                  state      <= S_RESP;
                end else begin
                  rsp_status <= ST_OK;
                  state      <= S_READ;
                end
              end
              OP_REPLACE: begin
                rsp_status <= in_range ? ST_OK : ST_RANGE;
                state      <= S_RESP;
              end
              OP_DISPATCH: begin
                kind <= WALK_DISP;
                idx  <= '0;
                wptr <= '0;
                if (total == '0) begin
                  rsp_status <= ST_NOT_READY;
                  state      <= S_RESP;
                end else begin
                  rsp_status <= ST_OK;
                  state      <= S_READ;
                end
              end
              OP_CLEAR: begin
                rsp_status <= ST_OK;
                total      <= '0;
                state      <= S_RESP;
              end
              default: begin
                rsp_status <= ST_OK;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_PROC;
        end
        S_PROC: begin
          if (proc_go) begin
            // Count runs and removals, or emit and compact
            if (count_only) begin
              if (step.emit) begin
                n_total <= n_total + RES_W'(1);
              end
              if (!step.keep) begin
                removed <= removed + CW'(1);
              end
            end else begin
              if (step.keep) begin
                wptr <= wptr + CW'(1);
              end
              if (pass2 && step.emit) begin
                out_valid    <= 1'b1;
                status       <= ST_OK;
                run_task_id  <= rd_data.id;
                run_task_arg <= rd_data.arg;
                last         <= (emitted == n_total - RES_W'(1));
                task_count   <= 5'(final_cnt);
                emitted      <= emitted + RES_W'(1);
              end
            end
            // Advance to the next entry or finish the walk
            if (idx_inc == total) begin
              if (kind == WALK_DISP) begin
                if (pass2) begin
                  total <= final_cnt;
                  state <= S_IDLE;
                end else if (n_total == '0 && !step.emit) begin
                  rsp_status <= ST_NOT_READY;
                  state      <= S_RESP;
                end else begin
                  pass2 <= 1'b1;
                  idx   <= '0;
                  wptr  <= '0;
                  state <= S_READ;
                end
              end else begin
                if (kind == WALK_MOVE) begin
                  total <= total - CW'(1);
                end
                state <= S_RESP;
              end
            end else begin
              idx   <= idx_inc;
              state <= S_READ;
            end
          end
        end
        S_RESP: begin
          // Hand out the single result of the operation
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= rsp_status;
            run_task_id  <= '0;
            run_task_arg <= '0;
            last         <= 1'b1;
            task_count   <= 5'(total);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The count never passes the table depth
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(MAX_TASKS))
    else $error("task count beyond table depth");

  // Compaction never writes ahead of the entry being read
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROC && !count_only) |-> (wptr <= idx))
    else $error("compaction write ahead of read");

  // The emitting pass never gives more results than the counting pass found
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROC && pass2 && step.emit) |-> (emitted < n_total))
    else $error("dispatch emitted more runs than counted");

  // A finished dispatch leaves the table at the counted size
  a_disp_count: assert property (@(posedge clk) disable iff (rst)
    (proc_go && pass2 && idx_inc == total) |=> (total == $past(final_cnt)))
    else $error("dispatch left wrong task count");

endmodule

[tb/cts_checker.sv]
// ----------------------------------------------------------------------------
// cts_checker
// Watches both channels of the cooperative task scheduler, keeps a shadow
// task table, works out the results of every accepted item and compares
// each accepted result, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module cts_checker
  import cts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [3:0]  position,
  input  logic [7:0]  task_id,
  input  logic [15:0] release_time,
  input  logic [15:0] period,
  input  logic [7:0]  run_count,
  input  logic [31:0] task_arg,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [7:0]  run_task_id,
  input  logic [31:0] run_task_arg,
  input  logic        last,
  input  logic [4:0]  task_count,
  output int          fail_count,
  output int          results_due,
  output int          table_size
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  id;
    logic [31:0] arg;
    logic        last;
    logic [4:0]  count;
  } run_result_t;

  entry_t      task_table [MAX_TASKS];
  int          entry_total = 0;
  run_result_t due_results[$];
  run_result_t want;
  int          mismatches = 0;

  assign fail_count = mismatches;

  initial begin
    results_due = 0;
    table_size  = 0;
    foreach (task_table[i]) task_table[i] = '0;
  end

  // Apply one item to the shadow table and queue the results it causes
  task automatic schedule_step(input logic [2:0] op, input logic [3:0] pos,
                               input entry_t fresh);
    run_result_t res[MAX_RESULTS];
    int          n;
    int          w;
    bit          keep;
    n = 1;
    res[0] = '0;
    res[0].status = ST_OK;
    res[0].last = 1'b1;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < entry_total; i++) begin
          if (task_table[i].id != 8'd0) begin
            if (task_table[i].delay == 16'd0) begin
              if (task_table[i].pending != 8'hFF)
                task_table[i].pending = task_table[i].pending + 8'd1;
              if (task_table[i].period != 16'd0)
                task_table[i].delay = task_table[i].period;
            end else begin
              task_table[i].delay = task_table[i].delay - 16'd1;
            end
          end
        end
      end
      OP_ADD: begin
        if (entry_total >= MAX_TASKS) begin
          res[0].status = ST_FULL;
        end else begin
          task_table[entry_total] = fresh;
          entry_total++;
        end
      end
      OP_DELETE: begin
        if (pos >= entry_total) begin
          res[0].status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < entry_total; i++)
            task_table[i] = task_table[i + 1];
          entry_total--;
        end
      end
      OP_REPLACE: begin
        if (pos >= entry_total)
          res[0].status = ST_RANGE;
        else
          task_table[pos] = fresh;
      end
      OP_DISPATCH: begin
        // Emit pending entries in order, drop one-shots, compact the rest
        n = 0;
        w = 0;
        for (int i = 0; i < entry_total; i++) begin
          keep = 1'b1;
          if (task_table[i].pending != 8'd0 && n < MAX_RESULTS) begin
            res[n] = '0;
            res[n].status = ST_OK;
            res[n].id = task_table[i].id;
            res[n].arg = task_table[i].arg;
            n++;
            task_table[i].pending = task_table[i].pending - 8'd1;
            if (task_table[i].period == 16'd0)
              keep = 1'b0;
          end
          if (keep) begin
            task_table[w] = task_table[i];
            w++;
          end
        end
        entry_total = w;
        if (n == 0) begin
          n = 1;
          res[0].status = ST_NOT_READY;
        end else begin
          res[n - 1].last = 1'b1;
        end
      end
      OP_CLEAR: begin
        entry_total = 0;
      end
      default: begin
      end
    endcase
    for (int k = 0; k < n; k++) begin
      res[k].count = entry_total[4:0];
      due_results.push_back(res[k]);
    end
  endtask

  // Predict on each accepted item, compare each accepted result
  always @(posedge clk) begin
    entry_t fresh;
    if (rst) begin
      entry_total = 0;
      due_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        fresh.id      = task_id;
        fresh.arg     = task_arg;
        fresh.delay   = release_time;
        fresh.period  = period;
        fresh.pending = run_count;
        schedule_step(opcode, position, fresh);
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result with nothing due: status %0d id %0d arg %h last %0d count %0d",
                 status, run_task_id, run_task_arg, last, task_count);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (run_task_id !== want.id) begin
            $error("run_task_id: expected %0d, got %0d", want.id, run_task_id);
            mismatches++;
          end
          if (run_task_arg !== want.arg) begin
            $error("run_task_arg: expected %h, got %h", want.arg, run_task_arg);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            mismatches++;
          end
          if (task_count !== want.count) begin
            $error("task_count: expected %0d, got %0d", want.count, task_count);
            mismatches++;
          end
        end
      end
    end
    results_due <= due_results.size();
    table_size  <= entry_total;
  end

endmodule

[tb/tb_cooperative_task_scheduler.sv]
// ----------------------------------------------------------------------------
// tb_cooperative_task_scheduler
// Drives the scheduler with a directed opening (empty table, saturation,
// id zero with a pending run, one-shot removal, range errors, unused
// opcodes) and then random sequences of adds, ticks, edits and dispatches
// mixed with noise, under bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_cooperative_task_scheduler;
  import cts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam int END_WAIT   = 200;
  localparam int ITEM_GOAL  = 120;

  localparam int SEQ_FILL     = 0;
  localparam int SEQ_NOISE    = 1;
  localparam int SEQ_EDIT     = 2;
  localparam int SEQ_WORKLOAD = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = OP_TICK;
  logic [3:0]  position = 4'd0;
  logic [7:0]  task_id = 8'd0;
  logic [15:0] release_time = 16'd0;
  logic [15:0] period = 16'd0;
  logic [7:0]  run_count = 8'd0;
  logic [31:0] task_arg = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  run_task_id;
  logic [31:0] run_task_arg;
  logic        last;
  logic [4:0]  task_count;

  int          fail_count;
  int          results_due;
  int          table_size;
  int          items_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [15:0] stall_tick = 16'd0;
  logic [1:0]  stall_mode = 2'd0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cooperative_task_scheduler u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .position     (position),
    .task_id      (task_id),
    .release_time (release_time),
    .period       (period),
    .run_count    (run_count),
    .task_arg     (task_arg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .run_task_id  (run_task_id),
    .run_task_arg (run_task_arg),
    .last         (last),
    .task_count   (task_count)
  );

  cts_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .position     (position),
    .task_id      (task_id),
    .release_time (release_time),
    .period       (period),
    .run_count    (run_count),
    .task_arg     (task_arg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .run_task_id  (run_task_id),
    .run_task_arg (run_task_arg),
    .last         (last),
    .task_count   (task_count),
    .fail_count   (fail_count),
    .results_due  (results_due),
    .table_size   (table_size)
  );

  // Stall the result side on a pattern that changes whenever the low bits of a free-running tick count are zero
  always @(posedge clk) begin
    stall_tick <= stall_tick + 16'd1;
    if (stall_tick[5:0] == 6'd0)
      stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ready <= (stall_tick[1:0] == 2'd0);
      default: out_ready <= (stall_tick[3:0] >= 4'd10);
    endcase
  end

  // Give up when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Present one item, hold it until accepted, then maybe idle a while
  task automatic send_item(input logic [2:0] op, input logic [3:0] pos,
                           input logic [7:0] id, input logic [15:0] rel,
                           input logic [15:0] per, input logic [7:0] cnt,
                           input logic [31:0] arg);
    int gap;
    in_valid     <= 1'b1;
    opcode       <= op;
    position     <= pos;
    task_id      <= id;
    release_time <= rel;
    period       <= per;
    run_count    <= cnt;
    task_arg     <= arg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_SPARE6 && op != OP_SPARE7)
      items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Send an operation carrying a task with short, mostly small timing
  task automatic send_task_op(input logic [2:0] op, input logic [3:0] pos);
    logic [7:0]  id;
    logic [15:0] rel;
    logic [15:0] per;
    logic [7:0]  cnt;
    id  = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    rel = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0:       per = 16'($urandom);
      1, 2, 3: per = 16'd0;
      default: per = 16'($urandom_range(1, 4));
    endcase
    cnt = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0;
    send_item(op, pos, id, rel, per, cnt, $urandom);
  endtask

  // Mostly a position inside the table, sometimes anywhere
  function automatic logic [3:0] pick_position();
    if ($urandom_range(0, 3) == 0 || table_size == 0)
      return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, table_size - 1));
  endfunction

  // Hold the input side until every due result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  initial begin
    int seq;
    int reps;
    bit first_seq;
    first_seq = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: empty table, then a small table with corner entries
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
    send_item(OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
    send_item(OP_DELETE, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
    send_item(OP_REPLACE, 4'd15, 8'd3, 16'd1, 16'd1, 8'd1, 32'd1);
    send_item(OP_ADD, 4'd0, 8'hFF, 16'd0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_ADD, 4'd0, 8'd0, 16'd0, 16'd0, 8'd1, 32'd0);
    send_item(OP_ADD, 4'd0, 8'd1, 16'd1, 16'd0, 8'd0, 32'h1234_5678);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
    send_item(OP_SPARE6, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
    send_item(OP_SPARE7, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_REPLACE, 4'd1, 8'hAA, 16'hFFFF, 16'd0, 8'd2, 32'hA5A5_A5A5);
    send_item(OP_REPLACE, 4'd3, 8'h55, 16'd0, 16'd0, 8'd0, 32'd0);
    send_item(OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
    drain();
    send_item(OP_DELETE, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
    send_item(OP_ADD, 4'd0, 8'd7, 16'd2, 16'd2, 8'd0, 32'h0BAD_F00D);
    send_item(OP_DELETE, 4'd1, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
    send_item(OP_CLEAR, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
    send_item(OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);

    // Random sequences; the first one fills the table past its limit
    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0:       seq = SEQ_FILL;
        1, 2:    seq = SEQ_NOISE;
        3:       seq = SEQ_EDIT;
        default: seq = SEQ_WORKLOAD;
      endcase
      if (first_seq)
        seq = SEQ_FILL;
      first_seq = 1'b0;
      case (seq)
        SEQ_FILL: begin
          send_item(OP_CLEAR, 4'($urandom), 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
          repeat (MAX_TASKS_DEF + 1) send_task_op(OP_ADD, 4'($urandom));
          send_item(OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
          send_item(OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
        end
        SEQ_NOISE: begin
          reps = $urandom_range(1, 4);
          repeat (reps)
            send_item(3'($urandom_range(0, 7)), 4'($urandom), 8'($urandom),
                      16'($urandom), 16'($urandom), 8'($urandom), $urandom);
        end
        SEQ_EDIT: begin
          reps = $urandom_range(1, 3);
          repeat (reps)
            send_task_op(($urandom_range(0, 1) == 0) ? OP_DELETE : OP_REPLACE,
                         pick_position());
        end
        default: begin
          if ($urandom_range(0, 3) == 0)
            send_item(OP_CLEAR, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
          reps = $urandom_range(1, 4);
          repeat (reps) send_task_op(OP_ADD, 4'($urandom));
          if ($urandom_range(0, 3) == 0)
            send_task_op(OP_REPLACE, pick_position());
          reps = $urandom_range(1, 5);
          repeat (reps) send_item(OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
          send_item(OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
          if ($urandom_range(0, 2) == 0)
            send_item(OP_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 32'd0);
        end
      endcase
      if ($urandom_range(0, 7) == 0)
        drain();
    end

    // Let the last results through, then give the verdict
    drain();
    repeat (END_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
